[hw/rtl/mail_header_value_extractor_defines.svh]
// Assertion macros shared by the extractor RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef MAIL_HEADER_VALUE_EXTRACTOR_DEFINES_SVH
`define MAIL_HEADER_VALUE_EXTRACTOR_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define MHVE_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define MHVE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MHVE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mhve_pkg.sv]
`timescale 1ns / 1ps

package mhve_pkg;

  // Longest header name that can be configured.
  localparam int NAME_MAX    = 16;
  localparam int NAME_LEN_W  = $clog2(NAME_MAX + 1);
  localparam int NAME_IDX_W  = $clog2(NAME_MAX);
  localparam int NAME_BITS   = 8 * NAME_MAX;
  localparam int VAL_LEN_W   = 16;
  localparam int CFG_DATA_W  = 64;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic KIND_VALUE   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    CFG_NAME_LOW  = 2'd0,
    CFG_NAME_HIGH = 2'd1,
    CFG_NAME_LEN  = 2'd2,
    CFG_MAX_LEN   = 2'd3
  } cfg_reg_e;

  typedef enum logic [9:0] {
    PH_MSG_START  = 10'b0000000001,
    PH_LINE_START = 10'b0000000010,
    PH_NAME       = 10'b0000000100,
    PH_COLON      = 10'b0000001000,
    PH_SKIPLINE   = 10'b0000010000,
    PH_LEAD       = 10'b0000100000,
    PH_LEAD_NL    = 10'b0001000000,
    PH_VALUE      = 10'b0010000000,
    PH_VAL_NL     = 10'b0100000000,
    PH_DONE       = 10'b1000000000
  } phase_e;

  typedef struct packed {
    logic [NAME_BITS-1:0]  name_bytes;
    logic [NAME_LEN_W-1:0] name_length;
    logic [VAL_LEN_W-1:0]  max_value_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           value_byte;
    logic                 kind;
    logic                 found;
    logic [VAL_LEN_W-1:0] value_length;
  } out_item_t;

  // Space, tab, LF, VT, FF and CR.
  function automatic logic is_ws(logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) ? (b + 8'h20) : b;
  endfunction

endpackage

[hw/rtl/mhve_cfg.sv]
`timescale 1ns / 1ps

module mhve_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  mhve_pkg::cfg_reg_e                 cfg_idx_i,
  input  logic [mhve_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output mhve_pkg::cfg_t                     cfg_o
);
  import mhve_pkg::*;

  logic [CFG_DATA_W-1:0] name_low_q, name_high_q;
  logic [NAME_LEN_W-1:0] name_len_q;
  logic [VAL_LEN_W-1:0]  max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_low_q  <= '0;
      name_high_q <= '0;
      name_len_q  <= NAME_LEN_W'(1);
      max_len_q   <= VAL_LEN_W'(255);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NAME_LOW:  name_low_q  <= cfg_data_i;
        CFG_NAME_HIGH: name_high_q <= cfg_data_i;
        CFG_NAME_LEN:  name_len_q  <= cfg_data_i[NAME_LEN_W-1:0];
        CFG_MAX_LEN:   max_len_q   <= cfg_data_i[VAL_LEN_W-1:0];
      endcase
    end
  end

  assign cfg_o.name_bytes    = {name_high_q, name_low_q};
  assign cfg_o.name_length   = name_len_q;
  assign cfg_o.max_value_len = max_len_q;

endmodule

[hw/rtl/mhve_core.sv]
`timescale 1ns / 1ps
`include "mail_header_value_extractor_defines.svh"

module mhve_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mhve_pkg::cfg_t       cfg_i,
  input  logic                 step_i,
  input  mhve_pkg::in_item_t   item_i,
  output logic                 res_valid_o,
  output mhve_pkg::out_item_t  res_o
);
  import mhve_pkg::*;

  phase_e                phase_q, phase_d;
  logic [NAME_LEN_W-1:0] idx_q, idx_d;
  logic [VAL_LEN_W-1:0]  cnt_q, cnt_d;
  logic [VAL_LEN_W-1:0]  trim_q, trim_d;
  logic                  found_q, found_d;

  logic [7:0]            b;
  logic                  b_ws, b_cont;
  logic [NAME_LEN_W-1:0] eff_len;
  logic [NAME_LEN_W-1:0] match_idx;
  logic [NAME_LEN_W-1:0] match_idx_inc;
  logic [7:0]            name_char;
  logic                  name_hit;
  phase_e                name_phase;
  phase_e                colon_phase;
  logic                  colon_hit;
  logic                  emit_req;
  logic [VAL_LEN_W-1:0]  cnt_inc;

  assign b       = item_i.data_byte;
  assign b_ws    = is_ws(b);
  // Only space, tab, VT and FF continue a folded line.
  assign b_cont  = b_ws && (b != CHAR_CR) && (b != CHAR_LF);
  assign eff_len = (cfg_i.name_length > NAME_LEN_W'(NAME_MAX)) ?
                   NAME_LEN_W'(NAME_MAX) : cfg_i.name_length;

  // At a line start the compare begins at the first name character.
  assign match_idx     = (phase_q == PH_NAME) ? idx_q : '0;
  assign match_idx_inc = match_idx + NAME_LEN_W'(1);
  assign name_char     = cfg_i.name_bytes[8 * match_idx[NAME_IDX_W-1:0] +: 8];
  assign name_hit      = (match_idx < eff_len) && (to_lower(b) == to_lower(name_char));

  always_comb begin
    if (b == CHAR_LF) begin
      name_phase = PH_LINE_START;
    end else if (name_hit) begin
      name_phase = (match_idx_inc >= eff_len) ? PH_COLON : PH_NAME;
    end else begin
      name_phase = PH_SKIPLINE;
    end
  end

  assign colon_hit = (b == CHAR_COLON);
  always_comb begin
    if (colon_hit) begin
      colon_phase = PH_LEAD;
    end else if (b == CHAR_LF) begin
      colon_phase = PH_LINE_START;
    end else if (!b_ws) begin
      colon_phase = PH_SKIPLINE;
    end else begin
      colon_phase = phase_q;
    end
  end

  assign cnt_inc = cnt_q + VAL_LEN_W'(1);

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    trim_d      = trim_q;
    found_d     = found_q;
    emit_req    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      if (item_i.end_of_data) begin
        res_valid_o        = 1'b1;
        res_o.kind         = KIND_SUMMARY;
        res_o.found        = found_q;
        res_o.value_length = found_q ? trim_q : '0;
        phase_d            = PH_MSG_START;
        idx_d              = '0;
        cnt_d              = '0;
        trim_d             = '0;
        found_d            = 1'b0;
      end else begin
        unique case (phase_q)
          PH_MSG_START, PH_LINE_START: begin
            if ((phase_q == PH_LINE_START) && ((b == CHAR_CR) || (b == CHAR_LF))) begin
              phase_d = PH_DONE;
            end else if (eff_len == '0) begin
              idx_d   = '0;
              phase_d = colon_phase;
              found_d = found_q | colon_hit;
            end else begin
              idx_d   = name_hit ? match_idx_inc : '0;
              phase_d = name_phase;
            end
          end
          PH_NAME: begin
            idx_d   = name_hit ? match_idx_inc : idx_q;
            phase_d = name_phase;
          end
          PH_COLON: begin
            phase_d = colon_phase;
            found_d = found_q | colon_hit;
          end
          PH_SKIPLINE: begin
            if (b == CHAR_LF) begin
              phase_d = PH_LINE_START;
            end
          end
          PH_LEAD: begin
            if (!b_ws) begin
              phase_d  = PH_VALUE;
              emit_req = 1'b1;
            end else if (b == CHAR_LF) begin
              phase_d = PH_LEAD_NL;
            end
          end
          PH_LEAD_NL: begin
            phase_d = b_cont ? PH_LEAD : PH_DONE;
          end
          PH_VALUE: begin
            if (b == CHAR_LF) begin
              phase_d = PH_VAL_NL;
            end
            emit_req = 1'b1;
          end
          PH_VAL_NL: begin
            if (b_cont) begin
              phase_d  = PH_VALUE;
              emit_req = 1'b1;
            end else begin
              phase_d = PH_DONE;
            end
          end
          default: begin
            phase_d = PH_DONE;
          end
        endcase

        // Bytes beyond the length limit are dropped silently.
        if (emit_req && (cnt_q < cfg_i.max_value_len)) begin
          cnt_d            = cnt_inc;
          trim_d           = b_ws ? trim_q : cnt_inc;
          res_valid_o      = 1'b1;
          res_o.value_byte = b;
          res_o.kind       = KIND_VALUE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MSG_START;
      idx_q   <= '0;
      cnt_q   <= '0;
      trim_q  <= '0;
      found_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      trim_q  <= trim_d;
      found_q <= found_d;
    end
  end

  `MHVE_ASSERT_ALWAYS(a_trim_within_count, trim_q <= cnt_q,
                      "trimmed length exceeds emitted byte count")
  `MHVE_ASSERT_NEXT(a_summary_clears, step_i && item_i.end_of_data,
                    (phase_q == PH_MSG_START) && (cnt_q == '0) && !found_q,
                    "state not cleared after summary")
  `MHVE_ASSERT_IMPL(a_value_needs_found, res_valid_o && (res_o.kind == KIND_VALUE),
                    found_q, "value byte emitted before header matched")

endmodule

[hw/rtl/mhve_out_buf.sv]
`timescale 1ns / 1ps
`include "mail_header_value_extractor_defines.svh"

module mhve_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mhve_pkg::out_item_t  push_data_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mhve_pkg::out_item_t  out_data_o
);
  import mhve_pkg::*;

  logic      main_valid_q, main_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t main_q, main_d;
  out_item_t skid_q, skid_d;
  logic      pop;

  assign pop     = main_valid_q && !out_stall_i;
  assign ready_o = !skid_valid_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  `MHVE_ASSERT_ALWAYS(a_skid_implies_main, !skid_valid_q || main_valid_q,
                      "skid entry held while output register is empty")
  `MHVE_ASSERT_IMPL(a_no_push_when_full, skid_valid_q, !push_i,
                    "result pushed while skid entry is occupied")

endmodule

[hw/rtl/mail_header_value_extractor.sv]
// A beat accepted into the input register is scanned from there into the output register.
// Throughput: one input beat per cycle while the skid entry is free; every byte is handled by
// a single state update. An input register and a two-entry output stage keep both stall paths
// registered. Reset (rst_ni low, asynchronous) empties both stages, returns the scanner to
// message start and loads the registers with name length 1 and value limit 255.
`timescale 1ns / 1ps

module mail_header_value_extractor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  mhve_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output mhve_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  mhve_pkg::cfg_reg_e              cfg_idx_i,
  input  logic [mhve_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mhve_pkg::*;

  // Configuration registers. The user must see that they are only written while no message
  // is in flight, so the scanner sees them as constants; the block itself does not enforce it.
  cfg_t cfg;

  mhve_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input register. The beat held here is processed as soon as the output stage
  // has room, which is every cycle unless the skid entry is occupied. The stall
  // therefore depends only on flops and never on out_stall_i directly.
  logic     in_valid_q, in_valid_d;
  in_item_t in_q;
  logic     in_accept;
  logic     buf_ready;
  logic     step;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign step       = in_valid_q && buf_ready;
  assign in_stall_o = in_valid_q && !buf_ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  // Header scanner: one phase update per byte, producing at most one result.
  logic      res_valid;
  out_item_t res;

  mhve_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .item_i      (in_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register with a skid entry, so a result that meets a stall is kept
  // while the next byte is already being scanned.
  mhve_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (buf_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[tb/mhve_value_checker.sv]
`timescale 1ns / 1ps

module mhve_value_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  mhve_pkg::in_item_t              in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  mhve_pkg::out_item_t             out_data_i,
  input  logic                            cfg_we_i,
  input  mhve_pkg::cfg_reg_e              cfg_idx_i,
  input  logic [mhve_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              outstanding_o,
  output int                              mismatches_o
);
  import mhve_pkg::*;

  localparam logic [7:0] CH_SP      = 8'h20;
  localparam logic [7:0] CH_HT      = 8'h09;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  // Shadow copy of the configuration registers.
  logic [NAME_BITS-1:0]  name_chars;
  logic [NAME_LEN_W-1:0] name_len;
  logic [VAL_LEN_W-1:0]  value_cap;

  // Scanner state of the header search.
  phase_e               scan;
  logic [4:0]           match_pos;
  logic [VAL_LEN_W-1:0] emitted;
  logic [VAL_LEN_W-1:0] kept_len;
  logic                 header_seen;

  out_item_t value_beats_q[$];
  int        mismatch_cnt = 0;

  assign mismatches_o = mismatch_cnt;

  function automatic logic is_blank(logic [7:0] b);
    return (b == CH_SP) || ((b >= CH_HT) && (b <= CHAR_CR));
  endfunction

  function automatic logic [7:0] fold_lower(logic [7:0] b);
    return ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ? (b | 8'h20) : b;
  endfunction

  function automatic int name_span();
    return (name_len > NAME_MAX) ? NAME_MAX : int'(name_len);
  endfunction

  function automatic void reset_scan();
    scan        = PH_MSG_START;
    match_pos   = '0;
    emitted     = '0;
    kept_len    = '0;
    header_seen = 1'b0;
  endfunction

  // A value byte only leaves the block while the copy limit has room.
  function automatic void emit_value(logic [7:0] b);
    out_item_t beat;
    if (emitted >= value_cap) return;
    emitted = emitted + 1'b1;
    if (!is_blank(b)) kept_len = emitted;
    beat            = '0;
    beat.value_byte = b;
    beat.kind       = KIND_VALUE;
    value_beats_q.push_back(beat);
  endfunction

  function automatic void await_colon(logic [7:0] b);
    if (b == CHAR_COLON) begin
      header_seen = 1'b1;
      scan        = PH_LEAD;
    end else if (b == CHAR_LF) begin
      scan = PH_LINE_START;
    end else if (!is_blank(b)) begin
      scan = PH_SKIPLINE;
    end
  endfunction

  function automatic void match_char(logic [7:0] b);
    int n;
    n = name_span();
    if (b == CHAR_LF) begin
      scan = PH_LINE_START;
    end else if ((int'(match_pos) < n) &&
                 (fold_lower(b) == fold_lower(name_chars[match_pos*8 +: 8]))) begin
      match_pos = match_pos + 1'b1;
      scan      = (int'(match_pos) >= n) ? PH_COLON : PH_NAME;
    end else begin
      scan = PH_SKIPLINE;
    end
  endfunction

  function automatic void start_line(logic [7:0] b);
    match_pos = '0;
    if (name_span() == 0) await_colon(b);
    else match_char(b);
  endfunction

  function automatic void predict_beat(in_item_t beat);
    logic [7:0] b;
    logic       cont;
    out_item_t  summary;
    b = beat.data_byte;
    if (beat.end_of_data) begin
      summary              = '0;
      summary.kind         = KIND_SUMMARY;
      summary.found        = header_seen;
      summary.value_length = header_seen ? kept_len : '0;
      value_beats_q.push_back(summary);
      reset_scan();
      return;
    end
    // Only blanks that cannot end a line continue a folded header.
    cont = is_blank(b) && (b != CHAR_CR) && (b != CHAR_LF);
    case (scan)
      PH_MSG_START: start_line(b);
      PH_LINE_START: begin
        if ((b == CHAR_CR) || (b == CHAR_LF)) scan = PH_DONE;
        else start_line(b);
      end
      PH_NAME:  match_char(b);
      PH_COLON: await_colon(b);
      PH_SKIPLINE: begin
        if (b == CHAR_LF) scan = PH_LINE_START;
      end
      PH_LEAD: begin
        if (!is_blank(b)) begin
          scan = PH_VALUE;
          emit_value(b);
        end else if (b == CHAR_LF) begin
          scan = PH_LEAD_NL;
        end
      end
      PH_LEAD_NL: scan = cont ? PH_LEAD : PH_DONE;
      PH_VALUE: begin
        if (b == CHAR_LF) scan = PH_VAL_NL;
        emit_value(b);
      end
      PH_VAL_NL: begin
        if (cont) begin
          scan = PH_VALUE;
          emit_value(b);
        end else begin
          scan = PH_DONE;
        end
      end
      default: scan = PH_DONE;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_beat(input out_item_t got);
    out_item_t want;
    if (value_beats_q.size() == 0) begin
      report_mismatch("result beat with nothing pending", 32'(got), 0);
      return;
    end
    want = value_beats_q.pop_front();
    if (got.kind !== want.kind) report_mismatch("kind", 32'(got.kind), 32'(want.kind));
    if (got.value_byte !== want.value_byte) begin
      report_mismatch("value_byte", 32'(got.value_byte), 32'(want.value_byte));
    end
    if (got.found !== want.found) report_mismatch("found", 32'(got.found), 32'(want.found));
    if (got.value_length !== want.value_length) begin
      report_mismatch("value_length", 32'(got.value_length), 32'(want.value_length));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_chars = '0;
      name_len   = NAME_LEN_W'(1);
      value_cap  = VAL_LEN_W'(255);
      reset_scan();
      value_beats_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NAME_LOW:  name_chars[CFG_DATA_W-1:0]         = cfg_data_i;
          CFG_NAME_HIGH: name_chars[NAME_BITS-1:CFG_DATA_W] = cfg_data_i;
          CFG_NAME_LEN:  name_len  = cfg_data_i[NAME_LEN_W-1:0];
          CFG_MAX_LEN:   value_cap = cfg_data_i[VAL_LEN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_beat(out_data_i);
      if (in_valid_i && !in_stall_i) predict_beat(in_data_i);
      outstanding_o <= value_beats_q.size();
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import mhve_pkg::*;

  // The whole run should end well within this limit even with heavy idling,
  // so the limit only trips on a hang.
  localparam int LIMIT_CYCLES = 400000;
  // A byte that makes no result may still be in flight after the last result
  // has arrived.
  localparam int DRAIN_CYCLES = 8;
  localparam int ITEM_TARGET  = 1850;
  localparam int PHASE_COUNT  = 10;

  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_HT   = 8'h09;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_DASH = 8'h2D;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  cfg_reg_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int outstanding;
  int mismatches;
  int cycle_cnt = 0;

  // Idling knobs, in percent per cycle.
  int idle_pct;
  int stall_pct;

  // What the stimulus knows about the current name, so that it can write
  // header lines that match it, nearly match it or do not match at all.
  logic [7:0] hdr_name [NAME_MAX];
  int         hdr_len;

  // The message under construction and the number of beats sent so far.
  logic [7:0] msg_q [$];
  int         live_items;

  mail_header_value_extractor u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  mhve_value_checker u_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // The receiver stalls at random; stall_pct of zero gives a free-running sink.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("== FAIL ==");
    $finish;
  end

  // Offers one beat, with random idle cycles ahead of it, and returns at the
  // edge where the block takes it. The payload holds still while stalled.
  task automatic put_beat(input logic [7:0] b, input logic eod);
    in_item_t beat;
    beat.data_byte   = b;
    beat.end_of_data = eod;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Holds the sender back until every predicted result has been taken, then
  // lets the pipeline run empty of beats that make no result.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_name_char();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      c = 8'h61 + 8'($urandom_range(0, 25));
      if ($urandom_range(0, 1) == 1) c = c ^ 8'h20;
    end else if (r < 85) begin
      c = 8'h30 + 8'($urandom_range(0, 9));
    end else if (r < 90) begin
      c = CH_DASH;
    end else if (r < 94) begin
      c = 8'h00;
    end else begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // Loads a fresh name and limits. The phase number walks through the
  // extremes: full 16-character names, the empty name, lengths above the
  // maximum, a copy limit of zero and the largest copy limit.
  task automatic apply_settings(input int k);
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [CFG_DATA_W-1:0] word;
    int                    raw_len;
    int                    limit;
    int                    spot;
    for (int i = 0; i < NAME_MAX; i++) hdr_name[i] = pick_name_char();
    // Now and then a colon or a line feed sits inside the name.
    if ($urandom_range(0, 3) == 0) begin
      spot           = $urandom_range(0, NAME_MAX - 1);
      hdr_name[spot] = ($urandom_range(0, 1) == 1) ? CHAR_COLON : CHAR_LF;
    end
    case (k % 6)
      0: begin
        raw_len = 16;
        limit   = 65535;
      end
      1: begin
        raw_len = 0;
        limit   = 0;
      end
      2: begin
        raw_len = 31;
        limit   = 1;
      end
      3: begin
        raw_len = 1;
        limit   = 255;
      end
      4: begin
        raw_len = 17;
        limit   = $urandom_range(2, 12);
      end
      default: begin
        raw_len = $urandom_range(2, 15);
        limit   = $urandom_range(0, 40);
      end
    endcase
    hdr_len = (raw_len > NAME_MAX) ? NAME_MAX : raw_len;
    for (int i = 0; i < 8; i++) begin
      lo[i*8 +: 8] = hdr_name[i];
      hi[i*8 +: 8] = hdr_name[i+8];
    end
    settle();
    write_reg(CFG_NAME_LOW, lo);
    write_reg(CFG_NAME_HIGH, hi);
    // Bits above each field carry junk; the block must ignore them.
    word = {$urandom, $urandom};
    word[NAME_LEN_W-1:0] = raw_len[NAME_LEN_W-1:0];
    write_reg(CFG_NAME_LEN, word);
    word = {$urandom, $urandom};
    word[VAL_LEN_W-1:0] = limit[VAL_LEN_W-1:0];
    write_reg(CFG_MAX_LEN, word);
    cfg_we <= 1'b0;
  endtask

  // Blanks that may stand before the colon or ahead of the value; never LF.
  function automatic void push_ws(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 4);
      case (r)
        0: msg_q.push_back(CH_SP);
        1: msg_q.push_back(CH_HT);
        2: msg_q.push_back(CH_VT);
        3: msg_q.push_back(CH_FF);
        default: msg_q.push_back(CHAR_CR);
      endcase
    end
  endfunction

  // The first character of a folded continuation line.
  function automatic void push_fold();
    case ($urandom_range(0, 3))
      0: msg_q.push_back(CH_SP);
      1: msg_q.push_back(CH_HT);
      2: msg_q.push_back(CH_VT);
      default: msg_q.push_back(CH_FF);
    endcase
  endfunction

  // Mostly printable text, some blanks and now and then any byte at all.
  function automatic void push_text(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 80) msg_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
      else if (r < 90) msg_q.push_back(($urandom_range(0, 1) == 1) ? CH_SP : CH_HT);
      else msg_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // The first n name characters, with the case of letters flipped at random
  // since the match ignores case.
  function automatic void push_name(input int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = hdr_name[i];
      if (((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7A) && ($urandom_range(0, 1) == 1)) begin
        c = c ^ 8'h20;
      end
      msg_q.push_back(c);
    end
  endfunction

  function automatic void push_eol();
    if ($urandom_range(0, 9) < 7) begin
      msg_q.push_back(CHAR_LF);
    end else begin
      msg_q.push_back(CHAR_CR);
      msg_q.push_back(CHAR_LF);
    end
  endfunction

  // A header line that should match, with blanks before the colon, blanks
  // ahead of the value (sometimes across a fold), trailing blanks and
  // folded continuation lines.
  function automatic void push_match_line();
    push_name(hdr_len);
    if ($urandom_range(0, 2) == 0) push_ws($urandom_range(1, 2));
    msg_q.push_back(CHAR_COLON);
    push_ws($urandom_range(0, 3));
    if ($urandom_range(0, 5) == 0) begin
      msg_q.push_back(CHAR_LF);
      push_fold();
    end
    push_text($urandom_range(0, 20));
    if ($urandom_range(0, 2) == 0) push_ws($urandom_range(1, 2));
    repeat ($urandom_range(0, 2)) begin
      msg_q.push_back(CHAR_LF);
      push_fold();
      push_text($urandom_range(0, 8));
    end
  endfunction

  // Most messages are well-formed header blocks with random content, so that
  // the scanner gets past the name match into the value states. The rest is
  // pure noise or a message cut off at a random point.
  function automatic void build_message();
    int lines;
    int hit;
    msg_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 30)) msg_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    // A blank first line must not end the header block.
    if ($urandom_range(0, 9) == 0) push_eol();
    lines = $urandom_range(0, 4);
    hit   = $urandom_range(0, lines);
    for (int i = 0; i < lines; i++) begin
      if (i == hit) begin
        push_match_line();
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            // Some other header.
            push_text($urandom_range(1, 6));
            msg_q.push_back(CHAR_COLON);
            push_text($urandom_range(0, 10));
          end
          1: begin
            // Starts like the name, then strays.
            push_name($urandom_range(0, hdr_len));
            push_text($urandom_range(1, 8));
          end
          2: begin
            // The whole name but no colon.
            push_name(hdr_len);
            push_text($urandom_range(0, 6));
          end
          default: push_match_line();
        endcase
      end
      push_eol();
    end
    if ($urandom_range(0, 9) < 7) begin
      push_eol();
      // A matching line in the body comes after the search has ended.
      if ($urandom_range(0, 2) == 0) push_match_line();
      push_text($urandom_range(0, 10));
    end
    if ($urandom_range(0, 7) == 0) begin
      hit = $urandom_range(0, msg_q.size());
      while (msg_q.size() > hit) void'(msg_q.pop_back());
    end
  endfunction

  task automatic send_message();
    // Now and then the sender waits for the block to run dry.
    if ($urandom_range(0, 9) == 0) settle();
    foreach (msg_q[i]) put_beat(msg_q[i], 1'b0);
    put_beat(8'($urandom_range(0, 255)), 1'b1);
    live_items += msg_q.size() + 1;
  endtask

  initial begin
    int quota;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_we     <= 1'b0;
    cfg_idx    <= CFG_NAME_LOW;
    cfg_data   <= '0;
    rst_n      <= 1'b0;
    idle_pct   = 0;
    stall_pct  = 0;
    live_items = 0;
    hdr_len    = 1;
    foreach (hdr_name[i]) hdr_name[i] = 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed messages run on the reset settings: the name is a single NUL
    // character and up to 255 value bytes are copied.
    // A NUL name byte, a blank before the colon, a value byte of 0xFF and a
    // trailing blank that the summary trims off.
    msg_q = '{8'h00, CH_SP, CHAR_COLON, CH_HT, 8'h76, 8'hFF, CH_SP};
    send_message();
    // A blank first line, then a CR line that ends the headers; the byte
    // after it is ignored and the summary reports nothing found.
    msg_q = '{CHAR_LF, CHAR_CR, 8'h41};
    send_message();
    // A folded value followed by a line that does not continue it.
    msg_q = '{8'h00, CHAR_COLON, 8'h61, CHAR_LF, CH_HT, 8'h62, CHAR_LF, 8'h63};
    send_message();
    // CR before the colon, and a value made of nothing but folded blanks.
    msg_q = '{8'h00, CHAR_CR, CHAR_COLON, CHAR_LF, CH_SP, CHAR_LF, CHAR_LF};
    send_message();
    // An end marker with no message in front of it.
    put_beat(8'h5A, 1'b1);

    // Random phases, each with new settings and its own idling mix.
    for (int k = 0; k < PHASE_COUNT; k++) begin
      apply_settings(k);
      case (k % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 60;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 60;
        end
        default: begin
          idle_pct  = 38;
          stall_pct = 38;
        end
      endcase
      quota = (ITEM_TARGET * (k + 1)) / PHASE_COUNT;
      while (live_items < quota) begin
        build_message();
        send_message();
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
